### rtl/sls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sectioned LED strip package
// Codes, header constants and register map shared by the frame generator
// and its testbench.
// ----------------------------------------------------------------------------
package sls_pkg;

   typedef enum logic [2:0] {
      BTN_ON    = 3'd0,
      BTN_UP    = 3'd1,
      BTN_DOWN  = 3'd2,
      BTN_OFF   = 3'd3,
      BTN_SEC0  = 3'd4,
      BTN_SEC1  = 3'd5,
      BTN_SEC2  = 3'd6,
      BTN_SEC3  = 3'd7
   } button_type;

   localparam logic ACT_BUTTON = 1'b0;
   localparam logic ACT_FETCH  = 1'b1;

   localparam logic [7:0] HDR_BASE = 8'hE0;
   localparam logic [7:0] HDR_FULL = 8'h1F;

   localparam int         ENABLE_BITS      = 4;
   localparam logic [3:0] ENABLES_RESET    = 4'hF;
   localparam logic [7:0] LEVEL_STEP_RESET = 8'd8;

   localparam int          CSR_ADDR_W     = 3;
   localparam int          CSR_DATA_W     = 32;
   localparam logic        CSR_LEVEL_STEP = 1'b0;

endpackage
`default_nettype wire

### rtl/sls_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sectioned LED strip channel interfaces
// Valid/ready channels for input items and result words.
// ----------------------------------------------------------------------------
interface sls_req_if;
   logic       valid;
   logic       ready;
   logic       action;
   logic [2:0] button;

   modport source (output valid, output action, output button, input ready);
   modport sink (input valid, input action, input button, output ready);
endinterface

interface sls_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       byte_valid;
   logic       last_byte;
   logic       strip_power_off;
   logic       update_pending;

   modport source (
      output valid, output data_byte, output byte_valid, output last_byte,
      output strip_power_off, output update_pending, input ready
   );
   modport sink (
      input valid, input data_byte, input byte_valid, input last_byte,
      input strip_power_off, input update_pending, output ready
   );
endinterface
`default_nettype wire

### rtl/sectioned_led_strip_frame_generator.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sectioned LED strip frame generator
// Every word on the request channel is either a button release, which edits
// the lighting settings, or a fetch, which returns the next byte of a strip
// frame while a frame runs or an update is pending: a zero start word, one
// header/blue/green/red word per LED, a zero reset word and the zero end
// words. Every request yields exactly one response word carrying the byte,
// its valid and last flags, and the power and pending flags after the
// request. Level and section enables are captured when a frame starts.
// The request is processed in the cycle it is accepted and its response is
// registered in the output register. A new request is accepted every cycle
// while the receiver takes responses; the output register holds a response
// while the receiver stalls, and a request is still taken in that cycle if
// the receiver takes the held response. Reset empties the output register,
// turns the strip off, clears the level and pending flag, enables all
// sections and sets the level step to its default. The level step register
// is written over the APB port at byte address zero.
// ----------------------------------------------------------------------------
module sectioned_led_strip_frame_generator #(
   parameter int LED_COUNT     = 144,
   parameter int SECTION_COUNT = 4
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   sls_req_if.sink                                req_port,
   sls_rsp_if.source                              rsp_port,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [sls_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [sls_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [sls_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready
);

   localparam int END_WORDS   = ((LED_COUNT / 2) / 32) + 1;
   localparam int FRAME_BYTES = 4 * (LED_COUNT + 2 + END_WORDS);
   localparam int LED_END     = 4 * (LED_COUNT + 1);
   localparam int POS_W       = $clog2(FRAME_BYTES);
   localparam int LPS         = LED_COUNT / SECTION_COUNT;
   localparam int CNT_W       = (LPS > 1) ? $clog2(LPS) : 1;
   localparam int SEC_W       = (SECTION_COUNT > 4) ? 3 : 2;
   localparam logic [SEC_W-1:0] SEC_LAST  = SEC_W'(SECTION_COUNT - 1);
   localparam logic [SEC_W-1:0] SEC_FIRST = (LPS == 0) ? SEC_LAST : '0;
   localparam logic [CNT_W-1:0] CNT_LAST  = (LPS > 0) ? CNT_W'(LPS - 1) : '0;

   logic [7:0]       level_step_ff, level_step_in;
   logic [7:0]       colour_level_ff, colour_level_in;
   logic [3:0]       section_enables_ff, section_enables_in;
   logic             power_off_ff, power_off_in;
   logic             pending_ff, pending_in;
   logic [POS_W-1:0] pos_ff, pos_in;
   logic [7:0]       frame_level_ff, frame_level_in;
   logic [3:0]       frame_enables_ff, frame_enables_in;
   logic [SEC_W-1:0] sec_ff, sec_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;

   logic             rsp_valid_ff, rsp_valid_in;
   logic [7:0]       data_byte_ff, data_byte_in;
   logic             byte_valid_ff, byte_valid_in;
   logic             last_byte_ff, last_byte_in;
   logic             power_out_ff, power_out_in;
   logic             pending_out_ff, pending_out_in;

   logic accept;
   logic is_fetch;
   logic active;
   logic start;
   logic send;
   logic in_led;
   logic led_on;
   logic at_last;
   logic csr_write;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite
                       && (csr_paddr[2] == sls_pkg::CSR_LEVEL_STEP);
   assign csr_prdata = (csr_paddr[2] == sls_pkg::CSR_LEVEL_STEP)
                       ? {{(sls_pkg::CSR_DATA_W-8){1'b0}}, level_step_ff}
                       : '0;
   assign level_step_in = csr_write ? csr_pwdata[7:0] : level_step_ff;

   assign req_port.ready = !rsp_valid_ff || rsp_port.ready;
   assign accept   = req_port.valid && req_port.ready;
   assign is_fetch = (req_port.action == sls_pkg::ACT_FETCH);
   assign active   = (pos_ff != '0);
   assign start    = is_fetch && !active && pending_ff;
   assign send     = is_fetch && (active || pending_ff);
   assign in_led   = (32'(pos_ff) >= 32'd4) && (32'(pos_ff) < 32'(LED_END));
   assign led_on   = frame_enables_ff[sec_ff[1:0]];
   assign at_last  = (32'(pos_ff) >= 32'(FRAME_BYTES - 1));

   always_comb begin
      colour_level_in    = colour_level_ff;
      section_enables_in = section_enables_ff;
      power_off_in       = power_off_ff;
      pending_in         = pending_ff;
      pos_in             = pos_ff;
      frame_level_in     = frame_level_ff;
      frame_enables_in   = frame_enables_ff;
      sec_in             = sec_ff;
      cnt_in             = cnt_ff;
      data_byte_in       = 8'd0;
      byte_valid_in      = 1'b0;
      last_byte_in       = 1'b0;

      if (!is_fetch) begin
         case (req_port.button)
            sls_pkg::BTN_ON: begin
               power_off_in = 1'b0;
            end
            sls_pkg::BTN_UP: begin
               colour_level_in = colour_level_ff + level_step_ff;
            end
            sls_pkg::BTN_DOWN: begin
               colour_level_in = colour_level_ff - level_step_ff;
            end
            sls_pkg::BTN_OFF: begin
               power_off_in = 1'b1;
            end
            default: begin
               section_enables_in = section_enables_ff
                                    ^ (4'd1 << req_port.button[1:0]);
            end
         endcase
         pending_in = 1'b1;
      end else begin
         if (start) begin
            frame_level_in   = colour_level_ff;
            frame_enables_in = section_enables_ff;
            pending_in       = 1'b0;
            sec_in           = SEC_FIRST;
            cnt_in           = '0;
         end
         if (send) begin
            byte_valid_in = 1'b1;
            if (in_led) begin
               if (pos_ff[1:0] == 2'd0) begin
                  data_byte_in = led_on ? (sls_pkg::HDR_BASE | sls_pkg::HDR_FULL)
                                        : sls_pkg::HDR_BASE;
               end else begin
                  data_byte_in = led_on ? frame_level_ff : 8'd0;
               end
               if ((pos_ff[1:0] == 2'd3) && (LPS > 0)) begin
                  if (cnt_ff == CNT_LAST) begin
                     cnt_in = '0;
                     if (sec_ff < SEC_LAST) begin
                        sec_in = sec_ff + SEC_W'(1);
                     end
                  end else begin
                     cnt_in = cnt_ff + CNT_W'(1);
                  end
               end
            end
            if (at_last) begin
               last_byte_in = 1'b1;
               pos_in       = '0;
            end else begin
               pos_in = pos_ff + POS_W'(1);
            end
         end
      end

      power_out_in   = power_off_in;
      pending_out_in = pending_in;

      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_port.ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_step_ff      <= sls_pkg::LEVEL_STEP_RESET;
         colour_level_ff    <= 8'd0;
         section_enables_ff <= sls_pkg::ENABLES_RESET;
         power_off_ff       <= 1'b1;
         pending_ff         <= 1'b0;
         pos_ff             <= '0;
         frame_level_ff     <= 8'd0;
         frame_enables_ff   <= sls_pkg::ENABLES_RESET;
         sec_ff             <= SEC_FIRST;
         cnt_ff             <= '0;
         rsp_valid_ff       <= 1'b0;
      end else begin
         level_step_ff <= level_step_in;
         rsp_valid_ff  <= rsp_valid_in;
         if (accept) begin
            colour_level_ff    <= colour_level_in;
            section_enables_ff <= section_enables_in;
            power_off_ff       <= power_off_in;
            pending_ff         <= pending_in;
            pos_ff             <= pos_in;
            frame_level_ff     <= frame_level_in;
            frame_enables_ff   <= frame_enables_in;
            sec_ff             <= sec_in;
            cnt_ff             <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_byte_ff   <= data_byte_in;
         byte_valid_ff  <= byte_valid_in;
         last_byte_ff   <= last_byte_in;
         power_out_ff   <= power_out_in;
         pending_out_ff <= pending_out_in;
      end
   end

   assign rsp_port.valid           = rsp_valid_ff;
   assign rsp_port.data_byte       = data_byte_ff;
   assign rsp_port.byte_valid      = byte_valid_ff;
   assign rsp_port.last_byte       = last_byte_ff;
   assign rsp_port.strip_power_off = power_out_ff;
   assign rsp_port.update_pending  = pending_out_ff;

endmodule
`default_nettype wire

### sim/sectioned_led_strip_frame_generator_test.sv
`default_nettype none
// ----------------------------------------------------------------------------
// Sectioned LED strip frame generator testbench
// Drives button releases and byte fetches into the frame generator, keeps a
// model of the lighting settings and the frame in flight, and checks every
// response word field by field. The level step register is set to several
// values between phases, while the block is idle.
// ----------------------------------------------------------------------------
module sectioned_led_strip_frame_generator_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int LED_COUNT     = 144;
   localparam int SECTION_COUNT = 4;
   localparam int LEDS_PER_SEC  = LED_COUNT / SECTION_COUNT;
   localparam int END_WORDS     = ((LED_COUNT / 2) / 32) + 1;
   localparam int FRAME_LEN     = 4 * (LED_COUNT + 2 + END_WORDS);

   localparam logic [sls_pkg::CSR_ADDR_W-1:0] LEVEL_STEP_ADDR =
      sls_pkg::CSR_ADDR_W'(4 * int'(sls_pkg::CSR_LEVEL_STEP));

   typedef struct {
      logic                action;
      sls_pkg::button_type button;
   } strip_request_type;

   typedef struct {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last_byte;
      logic       strip_power_off;
      logic       update_pending;
   } strip_word_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                           csr_psel    = 1'b0;
   logic                           csr_penable = 1'b0;
   logic                           csr_pwrite  = 1'b0;
   logic [sls_pkg::CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [sls_pkg::CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [sls_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                           csr_pready;

   sls_req_if req_if ();
   sls_rsp_if rsp_if ();

   initial begin
      req_if.valid  = 1'b0;
      req_if.action = sls_pkg::ACT_BUTTON;
      req_if.button = sls_pkg::BTN_ON;
      rsp_if.ready  = 1'b0;
   end

   sectioned_led_strip_frame_generator #(
      .LED_COUNT     (LED_COUNT),
      .SECTION_COUNT (SECTION_COUNT)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_port    (req_if),
      .rsp_port    (rsp_if),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always #5 clock = ~clock;

   strip_request_type pending_items[$];
   strip_word_type    expected_words[$];
   int                error_count = 0;
   logic              req_taken = 1'b0;

   // Model state.
   logic [7:0] step_size;
   logic [7:0] level;
   logic [3:0] enables;
   logic       power_off;
   logic       pending;
   logic [9:0] position;
   logic [7:0] frame_level;
   logic [3:0] frame_enables;

   function automatic int led_section(input int led);
      int s;
      if (LEDS_PER_SEC == 0) begin
         return SECTION_COUNT - 1;
      end
      s = led / LEDS_PER_SEC;
      if (s > SECTION_COUNT - 1) begin
         s = SECTION_COUNT - 1;
      end
      return s;
   endfunction

   function automatic logic [7:0] frame_byte_at(input logic [9:0] pos);
      int   word;
      logic on;
      word = int'(pos >> 2);
      if (word < 1 || word > LED_COUNT) begin
         return 8'h00;
      end
      on = frame_enables[led_section(word - 1) % sls_pkg::ENABLE_BITS];
      if (pos[1:0] == 2'd0) begin
         return on ? (sls_pkg::HDR_BASE | sls_pkg::HDR_FULL) : sls_pkg::HDR_BASE;
      end
      return on ? frame_level : 8'h00;
   endfunction

   task automatic apply_request(input logic action, input sls_pkg::button_type button,
                                output strip_word_type word);
      logic active;
      word = '{8'h00, 1'b0, 1'b0, 1'b0, 1'b0};
      if (action == sls_pkg::ACT_BUTTON) begin
         case (button)
            sls_pkg::BTN_ON: begin
               power_off = 1'b0;
            end
            sls_pkg::BTN_UP: begin
               level = level + step_size;
            end
            sls_pkg::BTN_DOWN: begin
               level = level - step_size;
            end
            sls_pkg::BTN_OFF: begin
               power_off = 1'b1;
            end
            default: begin
               enables[button[1:0]] = ~enables[button[1:0]];
            end
         endcase
         pending = 1'b1;
      end else begin
         active = (position != 10'd0);
         if (!active && pending) begin
            frame_level   = level;
            frame_enables = enables;
            pending       = 1'b0;
            active        = 1'b1;
         end
         if (active) begin
            word.data_byte  = frame_byte_at(position);
            word.byte_valid = 1'b1;
            if (int'(position) >= FRAME_LEN - 1) begin
               word.last_byte = 1'b1;
               position       = 10'd0;
            end else begin
               position = position + 10'd1;
            end
         end
      end
      word.strip_power_off = power_off;
      word.update_pending  = pending;
   endtask

   task automatic compare_field(input string name, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
      if (exp_val !== act_val) begin
         $error("%s: expected 0x%02h, got 0x%02h", name, exp_val, act_val);
         error_count++;
      end
   endtask

   always @(posedge clock) begin : monitor
      strip_word_type want;
      strip_word_type next_word;
      if (reset) begin
         req_taken     = 1'b0;
         step_size     = sls_pkg::LEVEL_STEP_RESET;
         level         = 8'd0;
         enables       = sls_pkg::ENABLES_RESET;
         power_off     = 1'b1;
         pending       = 1'b0;
         position      = 10'd0;
         frame_level   = 8'd0;
         frame_enables = sls_pkg::ENABLES_RESET;
      end else begin
         if (rsp_if.valid && rsp_if.ready) begin
            if (expected_words.size() == 0) begin
               $error("response word arrived with no expectation waiting");
               error_count++;
            end else begin
               want = expected_words.pop_front();
               compare_field("data_byte", want.data_byte, rsp_if.data_byte);
               compare_field("byte_valid", 8'(want.byte_valid), 8'(rsp_if.byte_valid));
               compare_field("last_byte", 8'(want.last_byte), 8'(rsp_if.last_byte));
               compare_field("strip_power_off", 8'(want.strip_power_off),
                             8'(rsp_if.strip_power_off));
               compare_field("update_pending", 8'(want.update_pending),
                             8'(rsp_if.update_pending));
            end
         end
         req_taken = req_if.valid && req_if.ready;
         if (req_taken) begin
            apply_request(req_if.action, sls_pkg::button_type'(req_if.button), next_word);
            expected_words.push_back(next_word);
         end
      end
   end

   // Sender: bursts of random length separated by random gaps.
   int burst_left = 1;
   int gap_left   = 0;

   always @(negedge clock) begin : driver
      logic              next_valid;
      strip_request_type item;
      next_valid = req_if.valid;
      if (!reset) begin
         if (req_taken) begin
            void'(pending_items.pop_front());
         end
         if (!(req_if.valid && !req_taken)) begin
            next_valid = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_items.size() > 0) begin
               item          = pending_items[0];
               next_valid    = 1'b1;
               req_if.action <= item.action;
               req_if.button <= item.button;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(50, 200)
                                                           : $urandom_range(1, 20);
                  gap_left   = $urandom_range(1, 8);
               end
            end
         end
      end
      req_if.valid <= next_valid;
   end

   // Receiver: alternating stretches of full flow, random stalls and long stalls.
   int stall_mode = 0;
   int mode_left  = 50;

   always @(negedge clock) begin : receiver
      logic next_ready;
      if (mode_left <= 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = (stall_mode == 2) ? $urandom_range(5, 30) : $urandom_range(20, 200);
      end
      mode_left--;
      case (stall_mode)
         0: next_ready = 1'b1;
         1: next_ready = 1'($urandom_range(0, 1));
         default: next_ready = ($urandom_range(0, 7) == 0);
      endcase
      rsp_if.ready <= next_ready;
   end

   task automatic push_request(input logic action, input sls_pkg::button_type button);
      strip_request_type item;
      item.action = action;
      item.button = button;
      pending_items.push_back(item);
   endtask

   task automatic push_fetches(input int count);
      repeat (count) begin
         push_request(sls_pkg::ACT_FETCH, sls_pkg::button_type'($urandom_range(0, 7)));
      end
   endtask

   task automatic fill_random(input int count);
      int done;
      int run;
      done = 0;
      while (done < count) begin
         if ($urandom_range(0, 9) == 0) begin
            run = $urandom_range(1, 4);
            if (run > count - done) begin
               run = count - done;
            end
            repeat (run) begin
               push_request(sls_pkg::ACT_BUTTON,
                            sls_pkg::button_type'($urandom_range(0, 7)));
            end
         end else begin
            run = $urandom_range(1, 150);
            if (run > count - done) begin
               run = count - done;
            end
            push_fetches(run);
         end
         done += run;
      end
   endtask

   task automatic wait_idle();
      do begin
         @(posedge clock);
      end while (pending_items.size() != 0 || req_if.valid || expected_words.size() != 0);
      repeat (3) @(posedge clock);
   endtask

   task automatic csr_write(input logic [sls_pkg::CSR_ADDR_W-1:0] addr,
                            input logic [7:0] value);
      @(negedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= addr;
      csr_pwdata  <= sls_pkg::CSR_DATA_W'(value);
      @(negedge clock);
      csr_penable <= 1'b1;
      do begin
         @(posedge clock);
      end while (!csr_pready);
      step_size = value;
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   initial begin : stimulus
      logic [7:0] step_values[5];
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      repeat (2) @(posedge clock);

      csr_write(LEVEL_STEP_ADDR, sls_pkg::LEVEL_STEP_RESET);
      push_fetches(1);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_DOWN);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_UP);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_UP);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_ON);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_OFF);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_ON);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_SEC0);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_SEC1);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_SEC2);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_SEC3);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_SEC1);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_SEC3);
      push_fetches(6);
      push_request(sls_pkg::ACT_BUTTON, sls_pkg::BTN_UP);
      push_fetches(3);
      wait_idle();

      step_values = '{8'd255, 8'd0, 8'd1, 8'($urandom_range(0, 255)), 8'd128};
      foreach (step_values[i]) begin
         csr_write(LEVEL_STEP_ADDR, step_values[i]);
         fill_random(290);
         wait_idle();
      end

      repeat (5) @(posedge clock);
      if (expected_words.size() != 0) begin
         $error("%0d expected response words never arrived", expected_words.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin : watchdog
      #5_000_000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
`default_nettype wire
